// ===== rtl/pit_pkg.sv =====
// shared widths and pipeline control types for the point-in-triangle test
// no dependencies
`default_nettype none
package pit_pkg;

  // coordinate width, two's complement, 16 fraction bits
  localparam int unsigned CoordWidth = 24;
  // edge vector component
  localparam int unsigned DiffWidth  = CoordWidth + 1;
  // product of a pair of edge components
  localparam int unsigned ProdWidth  = 2 * DiffWidth;
  // 2d cross product
  localparam int unsigned CrossWidth = ProdWidth + 1;
  // s + t - d
  localparam int unsigned SumWidth   = CrossWidth + 2;

  typedef logic signed [CoordWidth-1:0] coord_t;
  typedef logic signed [DiffWidth-1:0]  diff_t;
  typedef logic signed [ProdWidth-1:0]  prod_t;
  typedef logic signed [CrossWidth-1:0] cross_t;
  typedef logic signed [SumWidth-1:0]   sum_t;

  // load enables for the two stages inside the cross product unit
  typedef struct packed {
    logic en_mul;
    logic en_sub;
  } pit_stage_en_t;

endpackage
`default_nettype wire

// ===== rtl/pit_cross.sv =====
// two-stage 2d cross product x0*y1 - y0*x1: registered products, then registered difference
// depends on pit_pkg
`default_nettype none
module pit_cross (
  input  logic                  clk_i,
  input  pit_pkg::pit_stage_en_t stage_en_i,
  input  pit_pkg::diff_t        x0_i,
  input  pit_pkg::diff_t        y0_i,
  input  pit_pkg::diff_t        x1_i,
  input  pit_pkg::diff_t        y1_i,
  output pit_pkg::cross_t       cross_o
);
  import pit_pkg::*;

  prod_t  p0_q, p0_d;
  prod_t  p1_q, p1_d;
  cross_t cross_q, cross_d;

  always_comb begin
    p0_d    = prod_t'(x0_i) * prod_t'(y1_i);
    p1_d    = prod_t'(y0_i) * prod_t'(x1_i);
    cross_d = cross_t'(p0_q) - cross_t'(p1_q);
  end

  // payload only, no reset
  always_ff @(posedge clk_i) begin
    if (stage_en_i.en_mul) begin
      p0_q <= p0_d;
      p1_q <= p1_d;
    end
    if (stage_en_i.en_sub) begin
      cross_q <= cross_d;
    end
  end

  assign cross_o = cross_q;

endmodule
`default_nettype wire

// ===== rtl/point_in_triangle_test.sv =====
// top level of the strict point-in-triangle test, four-stage pipeline
// depends on pit_pkg and pit_cross
`default_nettype none
// Accepts one request per cycle while in_ready_o is high (query point p and
// corners a, b, c, each 24-bit two's complement with 16 fraction bits) and
// returns one flag per request, in order, from the stage 4 register. The flag is
// 1 only when p lies strictly inside the triangle; points on an edge or a corner
// and degenerate triangles give 0. The test is exact: stage 1 forms the edge
// vectors c-a, b-a, p-a, stage 2 the six products of three cross products, stage 3
// the cross products d, s, t, and stage 4 checks signs and s+t against d. Each
// stage has a valid bit and loads whenever it is empty or the stage after it
// moves, so a stall on the output backs up through the pipe without losing or
// repeating a request; in_ready_o is high while any stage can still advance.
module point_in_triangle_test (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  pit_pkg::coord_t point_x_i,
  input  pit_pkg::coord_t point_y_i,
  input  pit_pkg::coord_t corner_a_x_i,
  input  pit_pkg::coord_t corner_a_y_i,
  input  pit_pkg::coord_t corner_b_x_i,
  input  pit_pkg::coord_t corner_b_y_i,
  input  pit_pkg::coord_t corner_c_x_i,
  input  pit_pkg::coord_t corner_c_y_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic            inside_res_o
);
  import pit_pkg::*;

  // valid bits, one per stage
  logic v1_q, v2_q, v3_q, v4_q;
  // stage load enables
  logic en1, en2, en3, en4;

  // stage 1: edge vectors
  diff_t e0x_q, e0y_q, e1x_q, e1y_q, e2x_q, e2y_q;
  diff_t e0x_d, e0y_d, e1x_d, e1y_d, e2x_d, e2y_d;

  // stages 2 and 3 live in the cross units
  pit_stage_en_t stage_en;
  cross_t        d_cross, s_cross, t_cross;

  // stage 4: decision
  sum_t diff_sum;
  logic inside_d, inside_q;

  // backpressure chain: a stage loads when empty or when its successor moves
  always_comb begin
    en4 = !v4_q || out_ready_i;
    en3 = !v3_q || en4;
    en2 = !v2_q || en3;
    en1 = !v1_q || en2;
  end

  assign in_ready_o      = en1;
  assign stage_en.en_mul = en2;
  assign stage_en.en_sub = en3;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  // edge vectors, sign extended by one bit so the difference is exact
  always_comb begin
    e0x_d = diff_t'(corner_c_x_i) - diff_t'(corner_a_x_i);
    e0y_d = diff_t'(corner_c_y_i) - diff_t'(corner_a_y_i);
    e1x_d = diff_t'(corner_b_x_i) - diff_t'(corner_a_x_i);
    e1y_d = diff_t'(corner_b_y_i) - diff_t'(corner_a_y_i);
    e2x_d = diff_t'(point_x_i)    - diff_t'(corner_a_x_i);
    e2y_d = diff_t'(point_y_i)    - diff_t'(corner_a_y_i);
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      e0x_q <= e0x_d;
      e0y_q <= e0y_d;
      e1x_q <= e1x_d;
      e1y_q <= e1y_d;
      e2x_q <= e2x_d;
      e2y_q <= e2y_d;
    end
  end

  // d = e0 x e1
  pit_cross u_cross_d (
    .clk_i      (clk_i),
    .stage_en_i (stage_en),
    .x0_i       (e0x_q),
    .y0_i       (e0y_q),
    .x1_i       (e1x_q),
    .y1_i       (e1y_q),
    .cross_o    (d_cross)
  );

  // s = e2 x e1
  pit_cross u_cross_s (
    .clk_i      (clk_i),
    .stage_en_i (stage_en),
    .x0_i       (e2x_q),
    .y0_i       (e2y_q),
    .x1_i       (e1x_q),
    .y1_i       (e1y_q),
    .cross_o    (s_cross)
  );

  // t = e0 x e2
  pit_cross u_cross_t (
    .clk_i      (clk_i),
    .stage_en_i (stage_en),
    .x0_i       (e0x_q),
    .y0_i       (e0y_q),
    .x1_i       (e2x_q),
    .y1_i       (e2y_q),
    .cross_o    (t_cross)
  );

  // inside when d, s, t are nonzero with one sign and s + t lies strictly
  // between zero and d (so the "1" of u + v < 1 scales to d)
  always_comb begin
    diff_sum = sum_t'(s_cross) + sum_t'(t_cross) - sum_t'(d_cross);
    inside_d = 1'b0;
    if ((d_cross != '0) && (s_cross != '0) && (t_cross != '0) &&
        (s_cross[CrossWidth-1] == d_cross[CrossWidth-1]) &&
        (t_cross[CrossWidth-1] == d_cross[CrossWidth-1])) begin
      if (d_cross[CrossWidth-1]) begin
        // negative orientation: need s + t - d > 0
        inside_d = !diff_sum[SumWidth-1] && (diff_sum != '0);
      end else begin
        inside_d = diff_sum[SumWidth-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en4) begin
      inside_q <= inside_d;
    end
  end

  assign out_valid_o  = v4_q;
  assign inside_res_o = inside_q;

  // a full pipe is the only reason to refuse a request
  a_ready_only_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (v1_q && v2_q && v3_q && v4_q))
    else $error("input stalled while a pipeline stage is empty");

  // a finished cross product reaching a free output stage is never dropped
  a_stage4_fill : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en4 && v3_q) |=> v4_q)
    else $error("result lost between stage 3 and output");

  // a stalled result keeps its flag
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v4_q && !out_ready_i) |=> (v4_q && $stable(inside_q)))
    else $error("stalled result changed");

endmodule
`default_nettype wire

// ===== tb/point_in_triangle_test_test.sv =====
// testbench for the strict point-in-triangle test: directed and random queries,
// results checked in order against an exact integer predictor
// depends on pit_pkg and point_in_triangle_test
module point_in_triangle_test_test;

  // one request: query point p and the three triangle corners
  typedef struct packed {
    pit_pkg::coord_t px;
    pit_pkg::coord_t py;
    pit_pkg::coord_t ax;
    pit_pkg::coord_t ay;
    pit_pkg::coord_t bx;
    pit_pkg::coord_t by;
    pit_pkg::coord_t cx;
    pit_pkg::coord_t cy;
  } query_t;

  // one unit in 16-fraction-bit fixed point, and the coordinate extremes
  localparam int Unit = 65536;
  localparam int MaxC = 8388607;
  localparam int MinC = -8388608;
  localparam int NumRandom = 1100;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  // request side
  logic   in_valid = 1'b0;
  query_t offer = '0;
  logic   in_ready_o;

  // result side
  logic out_ready = 1'b0;
  logic out_valid_o;
  logic inside_res_o;

  query_t pending_queries[$];
  bit     inside_expected[$];
  bit     expected_flag;
  int     mismatch_cnt = 0;
  int     results_seen = 0;

  // cycle count drives the calm window, where neither side idles
  int   cycle_cnt = 0;
  logic calm;
  // long hold-off on the result side, so the pipe fills and stalls requests
  logic stall_out = 1'b0;

  assign calm = (cycle_cnt >= 600) && (cycle_cnt < 900);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  point_in_triangle_test i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .point_x_i   (offer.px),
    .point_y_i   (offer.py),
    .corner_a_x_i(offer.ax),
    .corner_a_y_i(offer.ay),
    .corner_b_x_i(offer.bx),
    .corner_b_y_i(offer.by),
    .corner_c_x_i(offer.cx),
    .corner_c_y_i(offer.cy),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .inside_res_o(inside_res_o)
  );

  // sign-extend a coordinate to 64 bits; every intermediate then stays exact
  function automatic longint as_long(pit_pkg::coord_t v);
    return v;
  endfunction

  // exact strict-inside test via the three 2d cross products:
  // d = e0 x e1, s = e2 x e1, t = e0 x e2 with e0 = c-a, e1 = b-a, e2 = p-a
  // inside iff d, s, t are nonzero with one sign and s + t stays short of d
  function automatic bit strictly_inside(query_t q);
    longint e0x, e0y, e1x, e1y, e2x, e2y;
    longint d, s, t, slack;
    bit d_neg;
    e0x = as_long(q.cx) - as_long(q.ax);
    e0y = as_long(q.cy) - as_long(q.ay);
    e1x = as_long(q.bx) - as_long(q.ax);
    e1y = as_long(q.by) - as_long(q.ay);
    e2x = as_long(q.px) - as_long(q.ax);
    e2y = as_long(q.py) - as_long(q.ay);
    d = e0x * e1y - e0y * e1x;
    s = e2x * e1y - e2y * e1x;
    t = e0x * e2y - e0y * e2x;
    // degenerate triangle, or point on the line through an edge from a
    if (d == 0 || s == 0 || t == 0) return 1'b0;
    d_neg = (d < 0);
    if ((s < 0) != d_neg || (t < 0) != d_neg) return 1'b0;
    // u + v < 1 scaled by d: the far edge b-c
    slack = s + t - d;
    return d_neg ? (slack > 0) : (slack < 0);
  endfunction

  task automatic add_query(input int px, py, ax, ay, bx, by, cx, cy);
    query_t q;
    q.px = pit_pkg::coord_t'(px);
    q.py = pit_pkg::coord_t'(py);
    q.ax = pit_pkg::coord_t'(ax);
    q.ay = pit_pkg::coord_t'(ay);
    q.bx = pit_pkg::coord_t'(bx);
    q.by = pit_pkg::coord_t'(by);
    q.cx = pit_pkg::coord_t'(cx);
    q.cy = pit_pkg::coord_t'(cy);
    pending_queries.insert(pending_queries.size(), q);
  endtask

  // any value of the full coordinate range
  function automatic int rand_coord();
    return int'(pit_pkg::coord_t'($urandom));
  endfunction

  // symmetric random offset in [-span, span]
  function automatic int jitter(int span);
    return int'($urandom_range(2 * span)) - span;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at result %0d: %s", results_seen, msg);
    mismatch_cnt++;
  endtask

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  // driver: offers queued requests, holds each one until it is taken, and
  // records the expected flag at the edge where the request is accepted
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready_o) begin
        inside_expected.insert(inside_expected.size(), strictly_inside(offer));
      end
      // a new request may go out when the slot is empty or just emptied
      if (!in_valid || in_ready_o) begin
        if (pending_queries.size() != 0 && !(($urandom_range(99) < 6) && !calm)) begin
          in_valid <= 1'b1;
          offer    <= pending_queries.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each accepted flag against the oldest expectation,
  // then decides whether to accept on the next edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid_o && out_ready) begin
        if (inside_expected.size() == 0) begin
          report_mismatch("result with no request outstanding");
        end else begin
          expected_flag = inside_expected.pop_front();
          if (inside_res_o !== expected_flag) begin
            report_mismatch($sformatf("inside_res %b, expected %b",
                                      inside_res_o, expected_flag));
          end
        end
        results_seen++;
      end
      out_ready <= !stall_out && !(($urandom_range(99) < 6) && !calm);
    end
  end

  // long result-side stall while the sender keeps offering requests
  initial begin
    @(posedge rst_ni);
    repeat (250) @(posedge clk_i);
    stall_out <= 1'b1;
    repeat (200) @(posedge clk_i);
    stall_out <= 1'b0;
  end

  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int ox, oy, span, kx, ky, m, sel;
    int ax, ay, bx, by, cx, cy, px, py;

    // all corners equal: degenerate at zero and at both extremes
    add_query(0, 0, 0, 0, 0, 0, 0, 0);
    add_query(MaxC, MaxC, MaxC, MaxC, MaxC, MaxC, MaxC, MaxC);
    add_query(MinC, MinC, MinC, MinC, MinC, MinC, MinC, MinC);
    // triangle spanning the whole range: inside, outside, at a corner, on an edge
    add_query(-4000000, -4000000, MinC, MinC, MaxC, MinC, MinC, MaxC);
    add_query(MaxC, MaxC, MinC, MinC, MaxC, MinC, MinC, MaxC);
    add_query(MinC, MinC, MinC, MinC, MaxC, MinC, MinC, MaxC);
    add_query(0, MinC, MinC, MinC, MaxC, MinC, MinC, MaxC);
    add_query(MinC + 1, MinC + 1, MinC, MinC, MaxC, MinC, MinC, MaxC);
    // mirrored full-range triangle, same winding
    add_query(1000000, 1000000, MaxC, MaxC, MinC, MaxC, MaxC, MinC);
    add_query(MinC, MinC, MaxC, MaxC, MinC, MaxC, MaxC, MinC);
    // unit triangle in both windings
    add_query(Unit / 4, Unit / 4, 0, 0, Unit, 0, 0, Unit);
    add_query(Unit / 4, Unit / 4, 0, 0, 0, Unit, Unit, 0);
    // on the far edge, one lsb inside it, one lsb beyond it
    add_query(Unit / 2, Unit / 2, 0, 0, Unit, 0, 0, Unit);
    add_query(Unit / 2 - 1, Unit / 2, 0, 0, Unit, 0, 0, Unit);
    add_query(Unit / 2 + 1, Unit / 2, 0, 0, Unit, 0, 0, Unit);
    // on edge a-c and at corner c
    add_query(0, Unit / 2, 0, 0, Unit, 0, 0, Unit);
    add_query(0, Unit, 0, 0, Unit, 0, 0, Unit);
    // collinear corners with the point on and off the line
    add_query(Unit, Unit, 0, 0, Unit, Unit, 2 * Unit, 2 * Unit);
    add_query(Unit, 0, 0, 0, Unit, Unit, 2 * Unit, 2 * Unit);
    // two corners coincide
    add_query(Unit / 4, Unit / 8, 0, 0, 0, 0, Unit, Unit);
    // smallest triangles around a lattice point, both signs
    add_query(1, 1, 0, 0, 3, 0, 0, 3);
    add_query(1, 2, 0, 0, 3, 0, 0, 3);
    add_query(-1, -1, 0, 0, -3, 0, 0, -3);

    for (int i = 0; i < NumRandom; i++) begin
      // local neighborhood kept clear of wraparound
      ox = rand_coord() / 4;
      oy = rand_coord() / 4;
      span = 1 << $urandom_range(20, 1);
      ax = ox + jitter(span);
      ay = oy + jitter(span);
      bx = ox + jitter(span);
      by = oy + jitter(span);
      cx = ox + jitter(span);
      cy = oy + jitter(span);
      sel = $urandom_range(99);
      if (sel < 30) begin
        // any bit pattern in every field
        add_query(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                  rand_coord(), rand_coord(), rand_coord(), rand_coord());
      end else if (sel < 58) begin
        // point in the same neighborhood as a small triangle
        add_query(ox + jitter(span), oy + jitter(span), ax, ay, bx, by, cx, cy);
      end else if (sel < 75) begin
        // near the centroid, mostly inside
        px = (ax + bx + cx) / 3 + jitter(2);
        py = (ay + by + cy) / 3 + jitter(2);
        add_query(px, py, ax, ay, bx, by, cx, cy);
      end else if (sel < 88) begin
        // point on an edge midpoint or on a corner
        kx = jitter(span / 2);
        ky = jitter(span / 2);
        bx = ax + 2 * kx;
        by = ay + 2 * ky;
        case ($urandom_range(3))
          0: begin
            px = ax + kx;
            py = ay + ky;
          end
          1: begin
            px = ax;
            py = ay;
          end
          2: begin
            px = bx;
            py = by;
          end
          default: begin
            px = cx;
            py = cy;
          end
        endcase
        // rotate corner roles so the edge lands on each side of the test
        if ($urandom_range(1)) begin
          add_query(px, py, ax, ay, bx, by, cx, cy);
        end else begin
          add_query(px, py, cx, cy, ax, ay, bx, by);
        end
      end else begin
        // degenerate: c on the line through a and b, including c = a and c = b
        kx = jitter(span);
        ky = jitter(span);
        m = int'($urandom_range(6)) - 3;
        bx = ax + kx;
        by = ay + ky;
        cx = ax + m * kx;
        cy = ay + m * ky;
        add_query(ox + jitter(span), oy + jitter(span), ax, ay, bx, by, cx, cy);
      end
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // drain: all requests taken, every flag back, then a final idle wait
    while (pending_queries.size() != 0 || in_valid) @(posedge clk_i);
    while (inside_expected.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (mismatch_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== point_in_triangle_test.f =====
rtl/pit_pkg.sv
rtl/pit_cross.sv
rtl/point_in_triangle_test.sv
tb/point_in_triangle_test_test.sv
